>>> rtl/sbht_pkg.sv
`default_nettype none

package sbht_pkg;

  // Field widths
  localparam int CoordBits = 24;
  localparam int FracBits  = 16;
  localparam int NumEdges  = 4;

  // Derived widths
  localparam int DW  = CoordBits + 1;      // deltas, far box corner, hit n and m
  localparam int NW  = CoordBits + 2;      // signed distance to an edge line
  localparam int PW  = 2 * CoordBits + 3;  // edge range products and their sum
  localparam int LW  = 2 * CoordBits;      // edge length times m
  localparam int CW  = 2 * DW;             // cross products n * m
  localparam int QW  = FracBits + 1;       // hit fraction
  localparam int RW  = CoordBits + 2;      // divider remainder

  localparam logic [QW-1:0] FracOne = {1'b1, {FracBits{1'b0}}};

  // Queue between front and back
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);

  typedef enum logic [2:0] {
    FaceNone   = 3'd0,
    FaceTop    = 3'd1,
    FaceLeft   = 3'd2,
    FaceRight  = 3'd3,
    FaceBottom = 3'd4
  } face_e;

  // Classified item: per edge crossing flag and s = n / m
  typedef struct packed {
    logic                         in_box;
    logic [NumEdges-1:0]          hit;
    logic [NumEdges-1:0][DW-1:0]  n;
    logic [NumEdges-1:0][DW-1:0]  m;
  } cand_t;

  // Nearest crossing
  typedef struct packed {
    logic          in_box;
    logic          hit;
    face_e         face;
    logic [DW-1:0] n;
    logic [DW-1:0] m;
  } best_t;

endpackage

`default_nettype wire

>>> rtl/sbht_front.sv
`default_nettype none

module sbht_front import sbht_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        in_valid_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic signed [CoordBits-1:0] box_x_i,
  input  logic signed [CoordBits-1:0] box_y_i,
  input  logic        [CoordBits-2:0] box_w_i,
  input  logic        [CoordBits-2:0] box_h_i,
  output logic                        valid_o,
  output cand_t                       cand_o
);

  logic [3:0] v_q;

  // Stage 1 inputs, per edge
  logic signed [DW-1:0]        x1, y1, dx, dy;
  logic                        in_box;
  logic signed [DW-1:0]        cross_w  [NumEdges];
  logic signed [DW-1:0]        sc_w     [NumEdges];
  logic signed [CoordBits-1:0] sa_w     [NumEdges];
  logic signed [CoordBits-1:0] orig_w   [NumEdges];
  logic signed [DW-1:0]        dc_w     [NumEdges];
  logic signed [DW-1:0]        da_w     [NumEdges];
  logic        [CoordBits-2:0] len_w    [NumEdges];

  // Stage registers
  logic                        inside1_q, inside2_q, inside3_q, inside4_q;
  logic signed [NW-1:0]        n0_q   [NumEdges];
  logic signed [DW-1:0]        dc_q   [NumEdges];
  logic signed [DW-1:0]        a1_q   [NumEdges];
  logic signed [DW-1:0]        da1_q  [NumEdges];
  logic        [CoordBits-2:0] len1_q [NumEdges];

  logic                        ok2_q  [NumEdges];
  logic        [DW-1:0]        n2_q   [NumEdges];
  logic        [DW-1:0]        m2_q   [NumEdges];
  logic signed [DW-1:0]        a2_q   [NumEdges];
  logic signed [DW-1:0]        da2_q  [NumEdges];
  logic        [CoordBits-2:0] len2_q [NumEdges];

  logic                        ok3_q  [NumEdges];
  logic        [DW-1:0]        n3_q   [NumEdges];
  logic        [DW-1:0]        m3_q   [NumEdges];
  logic signed [PW-1:0]        p1_q   [NumEdges];
  logic signed [PW-1:0]        p2_q   [NumEdges];
  logic        [LW-1:0]        lim_q  [NumEdges];

  logic        [NumEdges-1:0]  hit4_q;
  logic        [DW-1:0]        n4_q   [NumEdges];
  logic        [DW-1:0]        m4_q   [NumEdges];

  // Far corner, deltas and start-inside test
  always_comb begin
    x1 = DW'(box_x_i) + $signed({2'b00, box_w_i});
    y1 = DW'(box_y_i) + $signed({2'b00, box_h_i});
    dx = DW'(end_x_i) - DW'(start_x_i);
    dy = DW'(end_y_i) - DW'(start_y_i);
    in_box = (start_x_i >= box_x_i) && (start_x_i <= x1) &&
             (start_y_i >= box_y_i) && (start_y_i <= y1);
  end

  // Route operands for top, left, right and bottom edges
  always_comb begin
    cross_w[0] = DW'(box_y_i);  cross_w[1] = DW'(box_x_i);
    cross_w[2] = x1;            cross_w[3] = y1;
    sc_w[0]    = DW'(start_y_i); sc_w[1] = DW'(start_x_i);
    sc_w[2]    = DW'(start_x_i); sc_w[3] = DW'(start_y_i);
    sa_w[0]    = start_x_i;     sa_w[1]  = start_y_i;
    sa_w[2]    = start_y_i;     sa_w[3]  = start_x_i;
    orig_w[0]  = box_x_i;       orig_w[1] = box_y_i;
    orig_w[2]  = box_y_i;       orig_w[3] = box_x_i;
    dc_w[0]    = dy;            dc_w[1]  = dx;
    dc_w[2]    = dx;            dc_w[3]  = dy;
    da_w[0]    = dx;            da_w[1]  = dy;
    da_w[2]    = dy;            da_w[3]  = dx;
    len_w[0]   = box_w_i;       len_w[1] = box_h_i;
    len_w[2]   = box_h_i;       len_w[3] = box_w_i;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // Stage 1: distances to edge lines
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inside1_q <= in_box;
      for (int k = 0; k < NumEdges; k++) begin
        n0_q[k]   <= NW'(cross_w[k]) - NW'(sc_w[k]);
        dc_q[k]   <= dc_w[k];
        a1_q[k]   <= DW'(sa_w[k]) - DW'(orig_w[k]);
        da1_q[k]  <= da_w[k];
        len1_q[k] <= len_w[k];
      end
    end
  end

  // Stage 2: fold sign into n and m, check 0 <= s <= 1
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inside2_q <= inside1_q;
      for (int k = 0; k < NumEdges; k++) begin
        n2_q[k]   <= dc_q[k][DW-1] ? DW'(-n0_q[k]) : DW'(n0_q[k]);
        m2_q[k]   <= dc_q[k][DW-1] ? $unsigned(-dc_q[k]) : $unsigned(dc_q[k]);
        ok2_q[k]  <= (len1_q[k] != '0) && (dc_q[k] != '0) &&
                     (dc_q[k][DW-1] ? (n0_q[k] <= 0 && n0_q[k] >= dc_q[k])
                                    : (n0_q[k] >= 0 && n0_q[k] <= dc_q[k]));
        a2_q[k]   <= a1_q[k];
        da2_q[k]  <= da1_q[k];
        len2_q[k] <= len1_q[k];
      end
    end
  end

  // Stage 3: crossing point and edge length products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inside3_q <= inside2_q;
      for (int k = 0; k < NumEdges; k++) begin
        ok3_q[k] <= ok2_q[k];
        n3_q[k]  <= n2_q[k];
        m3_q[k]  <= m2_q[k];
        p1_q[k]  <= a2_q[k] * $signed({1'b0, m2_q[k]});
        p2_q[k]  <= $signed({1'b0, n2_q[k]}) * da2_q[k];
        lim_q[k] <= len2_q[k] * m2_q[k];
      end
    end
  end

  // Stage 4: crossing point must lie on the edge, ends included
  always_ff @(posedge clk_i) begin
    logic signed [PW-1:0] p;
    if (adv_i) begin
      inside4_q <= inside3_q;
      for (int k = 0; k < NumEdges; k++) begin
        p = p1_q[k] + p2_q[k];
        hit4_q[k] <= ok3_q[k] && !p[PW-1] &&
                     (p <= $signed({{(PW-LW){1'b0}}, lim_q[k]}));
        n4_q[k]   <= n3_q[k];
        m4_q[k]   <= m3_q[k];
      end
    end
  end

  always_comb begin
    cand_o.in_box = inside4_q;
    cand_o.hit    = hit4_q;
    for (int k = 0; k < NumEdges; k++) begin
      cand_o.n[k] = n4_q[k];
      cand_o.m[k] = m4_q[k];
    end
  end

  assign valid_o = v_q[3];

endmodule

`default_nettype wire

>>> rtl/sbht_fifo.sv
`default_nettype none

module sbht_fifo import sbht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cand_t data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output cand_t data_o
);

  cand_t           mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbht_select.sv
`default_nettype none

module sbht_select import sbht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  cand_t cand_i,
  output logic  valid_o,
  output best_t best_o
);

  typedef struct packed {
    logic          hit;
    face_e         face;
    logic [DW-1:0] n;
    logic [DW-1:0] m;
  } side_t;

  logic [3:0]    v_q;
  cand_t         cand1_q;
  logic [CW-1:0] c12a_q, c12b_q, c34a_q, c34b_q;
  logic          inside2_q, inside3_q;
  side_t         a2_q, b2_q, a3_q, b3_q;
  logic [CW-1:0] cba_q, cab_q;
  best_t         best_q;
  logic          pick12, pick34, pick_b;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // Stage 1: cross products within pairs
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cand1_q <= cand_i;
      c12a_q  <= cand_i.n[1] * cand_i.m[0];
      c12b_q  <= cand_i.n[0] * cand_i.m[1];
      c34a_q  <= cand_i.n[3] * cand_i.m[2];
      c34b_q  <= cand_i.n[2] * cand_i.m[3];
    end
  end

  // Stage 2: pair winners, earlier edge keeps a tie
  assign pick12 = cand1_q.hit[1] && (!cand1_q.hit[0] || (c12a_q < c12b_q));
  assign pick34 = cand1_q.hit[3] && (!cand1_q.hit[2] || (c34a_q < c34b_q));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inside2_q <= cand1_q.in_box;
      a2_q.hit  <= cand1_q.hit[0] | cand1_q.hit[1];
      a2_q.face <= pick12 ? FaceLeft : FaceTop;
      a2_q.n    <= pick12 ? cand1_q.n[1] : cand1_q.n[0];
      a2_q.m    <= pick12 ? cand1_q.m[1] : cand1_q.m[0];
      b2_q.hit  <= cand1_q.hit[2] | cand1_q.hit[3];
      b2_q.face <= pick34 ? FaceBottom : FaceRight;
      b2_q.n    <= pick34 ? cand1_q.n[3] : cand1_q.n[2];
      b2_q.m    <= pick34 ? cand1_q.m[3] : cand1_q.m[2];
    end
  end

  // Stage 3: cross products between pair winners
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inside3_q <= inside2_q;
      a3_q      <= a2_q;
      b3_q      <= b2_q;
      cba_q     <= b2_q.n * a2_q.m;
      cab_q     <= a2_q.n * b2_q.m;
    end
  end

  // Stage 4: final winner
  assign pick_b = b3_q.hit && (!a3_q.hit || (cba_q < cab_q));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      best_q.in_box <= inside3_q;
      best_q.hit    <= inside3_q | a3_q.hit | b3_q.hit;
      if (inside3_q) begin
        best_q.face <= FaceNone;
      end else if (pick_b) begin
        best_q.face <= b3_q.face;
      end else if (a3_q.hit) begin
        best_q.face <= a3_q.face;
      end else begin
        best_q.face <= FaceNone;
      end
      best_q.n <= pick_b ? b3_q.n : a3_q.n;
      best_q.m <= pick_b ? b3_q.m : a3_q.m;
    end
  end

  assign valid_o = v_q[3];
  assign best_o  = best_q;

endmodule

`default_nettype wire

>>> rtl/sbht_div.sv
`default_nettype none

module sbht_div import sbht_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  best_t         best_i,
  output logic          valid_o,
  output logic          hit_o,
  output logic          inside_o,
  output face_e         face_o,
  output logic [QW-1:0] quo_o
);

  logic [QW-1:0] v_q;
  logic [RW-1:0] rem_q    [QW];
  logic [QW-1:0] quo_q    [QW];
  logic [DW-1:0] m_q      [QW];
  logic          hit_q    [QW];
  logic          inside_q [QW];
  face_e         face_q   [QW];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [RW-1:0] rem_in, trial;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] m_in;
    logic          hit_in, inside_in, take;
    face_e         face_in;

    if (j == 0) begin : g_first
      assign rem_in    = RW'(best_i.n);
      assign quo_in    = '0;
      assign m_in      = best_i.m;
      assign hit_in    = best_i.hit;
      assign inside_in = best_i.in_box;
      assign face_in   = best_i.face;
      assign trial     = rem_in;
    end else begin : g_next
      assign rem_in    = rem_q[j-1];
      assign quo_in    = quo_q[j-1];
      assign m_in      = m_q[j-1];
      assign hit_in    = hit_q[j-1];
      assign inside_in = inside_q[j-1];
      assign face_in   = face_q[j-1];
      assign trial     = {rem_in[RW-2:0], 1'b0};
    end

    assign take = (trial >= RW'(m_in));

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[j]    <= take ? (trial - RW'(m_in)) : trial;
        quo_q[j]    <= {quo_in[QW-2:0], take};
        m_q[j]      <= m_in;
        hit_q[j]    <= hit_in;
        inside_q[j] <= inside_in;
        face_q[j]   <= face_in;
      end
    end
  end

  assign valid_o  = v_q[QW-1];
  assign hit_o    = hit_q[QW-1];
  assign inside_o = inside_q[QW-1];
  assign face_o   = face_q[QW-1];
  assign quo_o    = quo_q[QW-1];

endmodule

`default_nettype wire

>>> rtl/segment_box_hit_test.sv
`default_nettype none

// Channel | Handshake              | Payload
// in      | in_valid_i, in_ready_o | start_x_i start_y_i end_x_i end_y_i box_x_i box_y_i
//         |                        | box_w_i box_h_i
// out     | out_valid_o, out_ready_i | hit_o start_inside_o hit_fraction_o face_o
//
// One item per cycle sustained while the output is not stalled. Path with an empty queue:
// 4 front stages (edge setup and range products), the queue's storage
// register, 4 selection stages (two rounds of pairwise cross products) and a
// 17-stage divider, one quotient bit per stage, whose last stage is the
// output register.
// Reset clears valid bits and empties the queue; data registers are not reset.
// An output stall halts the back end; the 4-entry queue absorbs the front
// until full, then in_ready_o drops.

module segment_box_hit_test import sbht_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic signed [CoordBits-1:0] box_x_i,
  input  logic signed [CoordBits-1:0] box_y_i,
  input  logic        [CoordBits-2:0] box_w_i,
  input  logic        [CoordBits-2:0] box_h_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic                        start_inside_o,
  output logic        [QW-1:0]        hit_fraction_o,
  output logic        [2:0]           face_o
);

  logic          f_adv, b_adv;
  logic          front_valid, fifo_full, fifo_empty, fifo_push, fifo_pop;
  cand_t         front_cand, fifo_cand;
  logic          sel_valid;
  best_t         sel_best;
  logic          div_hit, div_inside;
  face_e         div_face;
  logic [QW-1:0] div_quo;

  // Front advances while the queue has room; back while the output can move
  assign f_adv      = !fifo_full;
  assign in_ready_o = f_adv;
  assign b_adv      = !out_valid_o || out_ready_i;
  assign fifo_push  = f_adv && front_valid;
  assign fifo_pop   = b_adv && !fifo_empty;

  sbht_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (f_adv),
    .in_valid_i (in_valid_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .box_x_i    (box_x_i),
    .box_y_i    (box_y_i),
    .box_w_i    (box_w_i),
    .box_h_i    (box_h_i),
    .valid_o    (front_valid),
    .cand_o     (front_cand)
  );

  sbht_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cand),
    .pop_i   (fifo_pop),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .data_o  (fifo_cand)
  );

  sbht_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (b_adv),
    .valid_i (!fifo_empty),
    .cand_i  (fifo_cand),
    .valid_o (sel_valid),
    .best_o  (sel_best)
  );

  sbht_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (b_adv),
    .valid_i  (sel_valid),
    .best_i   (sel_best),
    .valid_o  (out_valid_o),
    .hit_o    (div_hit),
    .inside_o (div_inside),
    .face_o   (div_face),
    .quo_o    (div_quo)
  );

  // Start inside reads as fraction zero; no hit saturates the fraction
  assign hit_o          = div_hit;
  assign start_inside_o = div_inside;
  assign face_o         = div_face;
  assign hit_fraction_o = div_inside ? '0 : (!div_hit ? '1 : div_quo);

  a_no_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_fraction_o == '1 && face_o == FaceNone &&
                              !start_inside_o)
    else $error("no-hit item carries stray fields");

  a_edge_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && !start_inside_o |-> face_o != FaceNone &&
                                              hit_fraction_o <= FracOne)
    else $error("edge hit without face or with fraction above one");

  a_queue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_empty && !fifo_push |=> fifo_empty)
    else $error("queue filled without a push");

endmodule

`default_nettype wire
